/* sv/wmc_pkg.sv */
// Shared types, constants and the coordinate-system lookup for the
// world-matrix composer. Depends on nothing; every other file imports it.

package wmc_pkg;

   localparam int QUAT_W     = 16;
   localparam int SCALE_W    = 16;
   localparam int Q16_W      = 32;
   localparam int ROT_W      = 35;
   localparam int PROD_W     = SCALE_W + ROT_W;
   localparam int ACC_W      = PROD_W + 1;
   localparam int FRAC_SHIFT = 20;
   localparam int QUEUE_DEPTH_DEFAULT = 2;

   localparam logic signed [ROT_W-1:0] ROT_ONE = ROT_W'(1) <<< 28;

   localparam logic [1:0] ROW_FIRST = 2'd0;
   localparam logic [1:0] ROW_LAST  = 2'd3;

   typedef enum logic [1:0] {
      MODE_RH_Y_UP = 2'd0,
      MODE_LH_Y_UP = 2'd1,
      MODE_RH_Z_UP = 2'd2,
      MODE_LH_Z_UP = 2'd3
   } coord_mode_type;

   typedef logic signed [QUAT_W-1:0]  quat_type;
   typedef logic signed [SCALE_W-1:0] scale_type;
   typedef logic signed [Q16_W-1:0]   q16_type;
   typedef logic signed [ROT_W-1:0]   rot_elem_type;

   typedef struct packed {
      quat_type  quat_x;
      quat_type  quat_y;
      quat_type  quat_z;
      quat_type  quat_w;
      scale_type scale_x;
      scale_type scale_y;
      scale_type scale_z;
      q16_type   pos_x;
      q16_type   pos_y;
      q16_type   pos_z;
   } req_payload_type;

   typedef struct packed {
      logic [1:0] row_index;
      q16_type    elem_0;
      q16_type    elem_1;
      q16_type    elem_2;
      logic       last_row;
   } rsp_payload_type;

   // One queued item: rotation block, scale and position.
   typedef struct packed {
      rot_elem_type [2:0][2:0] rot;
      scale_type    [2:0]      scale;
      q16_type      [2:0]      pos;
   } wmc_entry_type;

   // Handshake between queue and back end.
   typedef struct packed {
      logic valid;
      logic pop;
   } wmc_queue_ctrl_type;

   // Each row of a coordinate matrix has one nonzero entry, +1 or -1.
   typedef struct packed {
      logic [1:0] sel;
      logic       neg;
   } coord_pick_type;

   function automatic coord_pick_type coord_pick(input coord_mode_type mode,
                                                 input logic [1:0] row);
      coord_pick_type p;
      p.sel = (row == ROW_LAST) ? 2'd0 : row;
      p.neg = 1'b0;
      case (mode)
         MODE_RH_Y_UP: begin
            p.neg = (row == 2'd0);
         end
         MODE_LH_Y_UP: begin
            p.neg = 1'b0;
         end
         MODE_RH_Z_UP: begin
            case (row)
               2'd0:    begin p.sel = 2'd0; p.neg = 1'b1; end
               2'd1:    begin p.sel = 2'd2; p.neg = 1'b1; end
               2'd2:    begin p.sel = 2'd1; p.neg = 1'b0; end
               default: begin p.sel = 2'd0; p.neg = 1'b0; end
            endcase
         end
         MODE_LH_Z_UP: begin
            case (row)
               2'd0:    p.sel = 2'd0;
               2'd1:    p.sel = 2'd2;
               2'd2:    p.sel = 2'd1;
               default: p.sel = 2'd0;
            endcase
         end
         default: begin
            p.sel = 2'd0;
         end
      endcase
      return p;
   endfunction

endpackage

/* sv/world_matrix_compose.sv */
// Top level of the world-matrix composer: configuration register, front end,
// queue and back end. Depends on wmc_pkg, wmc_front, wmc_queue and wmc_back.

// Each input beat carries a rotation quaternion (Q1.14), a per-axis scale
// (Q8.8) and a position (Q16.16); the block returns four result beats, rows
// 0 to 3 of the row-vector world matrix C*S*R*T, three Q16.16 elements each
// with the constant fourth column left out. Row 3 is the position unchanged
// and carries last_row. C is picked by the two-bit csr register (reset 0,
// right-hand Y-up, which negates X); write it only while the block is idle.
// The quaternion is used as given, with no renormalisation. Rows 0 to 2 are
// rounded half up to Q16.16 and clamped. The back end produces one row per
// cycle through its three scale multipliers while the queue holds an item
// and rsp_stall is low. From acceptance an item passes the front register,
// the queue, the multiply stage and the output register before its first
// row appears. The queue between front and back lets a new item be taken
// while rows of the previous one are still leaving.

module world_matrix_compose import wmc_pkg::*; #(
   parameter int QUEUE_DEPTH = QUEUE_DEPTH_DEFAULT
) (
   input  logic            clock,
   input  logic            reset,
   input  logic            req_valid,
   output logic            req_stall,
   input  req_payload_type req_payload,
   output logic            rsp_valid,
   input  logic            rsp_stall,
   output rsp_payload_type rsp_payload,
   input  logic            csr_wr_en,
   input  logic [1:0]      csr_wr_data
);

   coord_mode_type     coord_mode_ff, coord_mode_in;
   logic               push_valid, push_ready;
   wmc_entry_type      push_entry;
   logic               pop_valid;
   wmc_queue_ctrl_type pop_ctrl;
   wmc_entry_type      pop_entry;

   // Hold the coordinate mode until the next write.
   always_comb begin
      coord_mode_in = coord_mode_ff;
      if (csr_wr_en) begin
         coord_mode_in = coord_mode_type'(csr_wr_data);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         coord_mode_ff <= MODE_RH_Y_UP;
      end else begin
         coord_mode_ff <= coord_mode_in;
      end
   end

   // Take in beats and form the rotation block.
   wmc_front u_front (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_stall   (req_stall),
      .req_payload (req_payload),
      .push_valid  (push_valid),
      .push_ready  (push_ready),
      .push_entry  (push_entry)
   );

   // Decouple the two sides.
   wmc_queue #(
      .DEPTH (QUEUE_DEPTH)
   ) u_queue (
      .clock      (clock),
      .reset      (reset),
      .push_valid (push_valid),
      .push_ready (push_ready),
      .push_entry (push_entry),
      .pop_valid  (pop_valid),
      .pop_ctrl   (pop_ctrl),
      .pop_entry  (pop_entry)
   );

   // Advance one matrix row per beat.
   wmc_back u_back (
      .clock       (clock),
      .reset       (reset),
      .coord_mode  (coord_mode_ff),
      .pop_valid   (pop_valid),
      .pop_ctrl    (pop_ctrl),
      .pop_entry   (pop_entry),
      .rsp_valid   (rsp_valid),
      .rsp_stall   (rsp_stall),
      .rsp_payload (rsp_payload)
   );

endmodule

/* sv/wmc_front.sv */
// Front end: accepts input beats and builds the quaternion rotation block.
// Depends on wmc_pkg.

module wmc_front import wmc_pkg::*; (
   input  logic            clock,
   input  logic            reset,
   input  logic            req_valid,
   output logic            req_stall,
   input  req_payload_type req_payload,
   output logic            push_valid,
   input  logic            push_ready,
   output wmc_entry_type   push_entry
);

   logic            valid_ff, valid_in;
   req_payload_type item_ff;
   logic            accept;

   logic signed [31:0] xx, yy, zz, xy, xz, yz, xw, yw, zw;

   function automatic rot_elem_type rot_diag(input logic signed [31:0] a,
                                             input logic signed [31:0] b);
      return ROT_ONE - ((ROT_W'(a) + ROT_W'(b)) <<< 1);
   endfunction

   function automatic rot_elem_type rot_pair(input logic signed [31:0] a,
                                             input logic signed [31:0] b,
                                             input logic sub);
      rot_elem_type sa, sb;
      sa = ROT_W'(a);
      sb = ROT_W'(b);
      return sub ? ((sa - sb) <<< 1) : ((sa + sb) <<< 1);
   endfunction

   assign req_stall  = valid_ff && !push_ready;
   assign accept     = req_valid && !req_stall;
   assign push_valid = valid_ff;

   always_comb begin
      valid_in = valid_ff;
      if (accept) begin
         valid_in = 1'b1;
      end else if (push_ready) begin
         valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         item_ff <= req_payload;
      end
   end

   always_comb begin
      xx = 32'(item_ff.quat_x) * 32'(item_ff.quat_x);
      yy = 32'(item_ff.quat_y) * 32'(item_ff.quat_y);
      zz = 32'(item_ff.quat_z) * 32'(item_ff.quat_z);
      xy = 32'(item_ff.quat_x) * 32'(item_ff.quat_y);
      xz = 32'(item_ff.quat_x) * 32'(item_ff.quat_z);
      yz = 32'(item_ff.quat_y) * 32'(item_ff.quat_z);
      xw = 32'(item_ff.quat_x) * 32'(item_ff.quat_w);
      yw = 32'(item_ff.quat_y) * 32'(item_ff.quat_w);
      zw = 32'(item_ff.quat_z) * 32'(item_ff.quat_w);

      push_entry.rot[0][0] = rot_diag(yy, zz);
      push_entry.rot[0][1] = rot_pair(xy, zw, 1'b0);
      push_entry.rot[0][2] = rot_pair(xz, yw, 1'b1);
      push_entry.rot[1][0] = rot_pair(xy, zw, 1'b1);
      push_entry.rot[1][1] = rot_diag(xx, zz);
      push_entry.rot[1][2] = rot_pair(yz, xw, 1'b0);
      push_entry.rot[2][0] = rot_pair(xz, yw, 1'b0);
      push_entry.rot[2][1] = rot_pair(yz, xw, 1'b1);
      push_entry.rot[2][2] = rot_diag(xx, yy);

      push_entry.scale[0] = item_ff.scale_x;
      push_entry.scale[1] = item_ff.scale_y;
      push_entry.scale[2] = item_ff.scale_z;
      push_entry.pos[0]   = item_ff.pos_x;
      push_entry.pos[1]   = item_ff.pos_y;
      push_entry.pos[2]   = item_ff.pos_z;
   end

endmodule

/* sv/wmc_queue.sv */
// Short register queue between front and back ends of the composer.
// Depends on wmc_pkg.

module wmc_queue import wmc_pkg::*; #(
   parameter int DEPTH = QUEUE_DEPTH_DEFAULT
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               push_valid,
   output logic               push_ready,
   input  wmc_entry_type      push_entry,
   output logic               pop_valid,
   input  wmc_queue_ctrl_type pop_ctrl,
   output wmc_entry_type      pop_entry
);

   localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CNT_W = $clog2(DEPTH + 1);
   localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(DEPTH - 1);
   localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(DEPTH);

   wmc_entry_type    slot_ff [DEPTH];
   logic [PTR_W-1:0] wr_ptr_ff, wr_ptr_in, rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0] count_ff, count_in;
   logic             push, pop;

   assign push_ready = (count_ff != CNT_FULL);
   assign pop_valid  = (count_ff != '0);
   assign push       = push_valid && push_ready;
   assign pop        = pop_ctrl.valid && pop_ctrl.pop && pop_valid;
   assign pop_entry  = slot_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == PTR_LAST) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == PTR_LAST) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (push && !pop) begin
         count_in = count_ff + 1'b1;
      end else if (pop && !push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         slot_ff[wr_ptr_ff] <= push_entry;
      end
   end

`ifndef SYNTHESIS
   assert property (@(posedge clock) disable iff (reset) count_ff <= CNT_FULL)
      else $error("queue fill count beyond depth");
   assert property (@(posedge clock) disable iff (reset)
      push && !pop |=> count_ff == $past(count_ff) + 1'b1)
      else $error("queue count missed a push");
`endif

endmodule

/* sv/wmc_back.sv */
// Back end: scales and signs the queued rotation block one row a beat,
// rounds to Q16.16 and holds the result beat. Depends on wmc_pkg.

module wmc_back import wmc_pkg::*; (
   input  logic               clock,
   input  logic               reset,
   input  coord_mode_type     coord_mode,
   input  logic               pop_valid,
   output wmc_queue_ctrl_type pop_ctrl,
   input  wmc_entry_type      pop_entry,
   output logic               rsp_valid,
   input  logic               rsp_stall,
   output rsp_payload_type    rsp_payload
);

   localparam logic signed [ACC_W-1:0] ROUND_HALF = ACC_W'(1) <<< (FRAC_SHIFT - 1);

   logic [1:0]  row_ff, row_in;
   logic        a_valid_ff, a_valid_in;
   logic [1:0]  a_row_ff;
   logic        a_neg_ff;
   logic signed [PROD_W-1:0] a_prod_ff [3];
   logic signed [PROD_W-1:0] prod_in   [3];
   q16_type     a_pos_ff [3];
   logic        out_valid_ff, out_valid_in;
   rsp_payload_type out_ff, out_in;

   logic        a_ready, b_ready, issue;
   coord_pick_type pick;
   scale_type   s_sel;
   logic signed [ACC_W-1:0] acc;
   logic signed [ACC_W-1:0] shifted;
   q16_type     elem [3];

   assign b_ready = !out_valid_ff || !rsp_stall;
   assign a_ready = !a_valid_ff || b_ready;
   assign issue   = pop_valid && a_ready;

   assign pop_ctrl.valid = issue;
   assign pop_ctrl.pop   = issue && (row_ff == ROW_LAST);

   // Pick the one source row of the rotation block for this output row.
   always_comb begin
      pick  = coord_pick(coord_mode, row_ff);
      s_sel = pop_entry.scale[pick.sel];
      for (int k = 0; k < 3; k++) begin
         prod_in[k] = PROD_W'(s_sel) * PROD_W'($signed(pop_entry.rot[pick.sel][k]));
      end
   end

   always_comb begin
      row_in     = row_ff;
      a_valid_in = a_valid_ff;
      if (issue) begin
         row_in = (row_ff == ROW_LAST) ? ROW_FIRST : row_ff + 1'b1;
      end
      if (a_ready) begin
         a_valid_in = issue;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         row_ff     <= ROW_FIRST;
         a_valid_ff <= 1'b0;
      end else begin
         row_ff     <= row_in;
         a_valid_ff <= a_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (issue) begin
         a_row_ff <= row_ff;
         a_neg_ff <= pick.neg;
         for (int k = 0; k < 3; k++) begin
            a_prod_ff[k] <= prod_in[k];
            a_pos_ff[k]  <= pop_entry.pos[k];
         end
      end
   end

   // Round half up at bit 20, then clamp to the Q16.16 range.
   always_comb begin
      acc     = '0;
      shifted = '0;
      for (int k = 0; k < 3; k++) begin
         acc = ACC_W'(a_prod_ff[k]);
         if (a_neg_ff) begin
            acc = -acc;
         end
         acc     = acc + ROUND_HALF;
         shifted = acc >>> FRAC_SHIFT;
         if (shifted[ACC_W-1:Q16_W-1] == '0 || shifted[ACC_W-1:Q16_W-1] == '1) begin
            elem[k] = shifted[Q16_W-1:0];
         end else if (shifted[ACC_W-1]) begin
            elem[k] = {1'b1, {(Q16_W-1){1'b0}}};
         end else begin
            elem[k] = {1'b0, {(Q16_W-1){1'b1}}};
         end
         if (a_row_ff == ROW_LAST) begin
            elem[k] = a_pos_ff[k];
         end
      end
      out_in.row_index = a_row_ff;
      out_in.elem_0    = elem[0];
      out_in.elem_1    = elem[1];
      out_in.elem_2    = elem[2];
      out_in.last_row  = (a_row_ff == ROW_LAST);
   end

   always_comb begin
      out_valid_in = out_valid_ff;
      if (b_ready) begin
         out_valid_in = a_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else begin
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (b_ready && a_valid_ff) begin
         out_ff <= out_in;
      end
   end

   assign rsp_valid   = out_valid_ff;
   assign rsp_payload = out_ff;

`ifndef SYNTHESIS
   assert property (@(posedge clock) disable iff (reset)
      pop_ctrl.pop |-> pop_valid && row_ff == ROW_LAST)
      else $error("queue entry dropped before its last row");
   assert property (@(posedge clock) disable iff (reset)
      issue && row_ff != ROW_LAST |=> row_ff == $past(row_ff) + 1'b1)
      else $error("row counter skipped a row");
   assert property (@(posedge clock) disable iff (reset)
      out_valid_ff |-> out_ff.last_row == (out_ff.row_index == ROW_LAST))
      else $error("last_row flag disagrees with row_index");
`endif

endmodule
